FILE: hw/rtl/stereo_audio_level_meter_unit_assert.svh
// Assertion macros used by the level meter checker.
`ifndef STEREO_AUDIO_LEVEL_METER_UNIT_ASSERT_SVH
`define STEREO_AUDIO_LEVEL_METER_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its condition.
`define SLM_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("level meter check failed (same cycle)");

// Check a consequence in the cycle after its condition.
`define SLM_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("level meter check failed (next cycle)");

`endif

FILE: hw/rtl/slm_pkg.sv
// Shared constants, codes, types and helpers of the stereo level meter.
`timescale 1ns / 1ps

package slm_pkg;

  // Default geometry
  localparam int SAMPLE_WIDTH_DEF  = 24;
  localparam int FRACTION_BITS_DEF = 20;
  localparam int CHANNELS          = 4;
  localparam int COUNTERS          = 7;
  localparam int REG_WIDTH         = 23;
  localparam int STAT_WIDTH        = 64;
  localparam int STAT_INDEX_WIDTH  = 5;

  localparam logic [STAT_WIDTH-1:0] TOP_VALUE = 64'h7FFF_FFFF_FFFF_FFFF;

  // Request types
  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Sample classes
  localparam logic [1:0] CLS_FINITE = 2'd0;
  localparam logic [1:0] CLS_NAN    = 2'd1;
  localparam logic [1:0] CLS_PINF   = 2'd2;
  localparam logic [1:0] CLS_NINF   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_CLIP_LEVEL   = 1'b0;
  localparam logic CFG_CHANGE_LEVEL = 1'b1;

  // Event counter slots
  localparam logic [2:0] CNT_CHANGED  = 3'd0;
  localparam logic [2:0] CNT_NAN      = 3'd1;
  localparam logic [2:0] CNT_INF      = 3'd2;
  localparam logic [2:0] CNT_CLIP_IN  = 3'd3;
  localparam logic [2:0] CNT_CLIP_OUT = 3'd4;
  localparam logic [2:0] CNT_FRAMES   = 3'd5;
  localparam logic [2:0] CNT_BLOCKS   = 3'd6;

  // Statistic numbers
  localparam logic [4:0] STAT_SQ_BASE   = 5'd0;
  localparam logic [4:0] STAT_PEAK_BASE = 5'd4;
  localparam logic [4:0] STAT_TP_BASE   = 5'd8;
  localparam logic [4:0] STAT_MIN_BASE  = 5'd12;
  localparam logic [4:0] STAT_MAX_BASE  = 5'd16;
  localparam logic [4:0] STAT_LDIFF     = 5'd20;
  localparam logic [4:0] STAT_DSUM      = 5'd21;
  localparam logic [4:0] STAT_CNT_BASE  = 5'd22;
  localparam logic [4:0] STAT_LAST      = 5'd28;

  // Per-channel flags handed from the front end to the update stage
  typedef struct packed {
    logic [1:0] cls;
    logic       clipped;
  } chan_flags_t;

  // Saturating add; acc stays at or below the top value and v below 2^63
  function automatic logic [STAT_WIDTH-1:0] sat_add(input logic [STAT_WIDTH-1:0] acc,
                                                    input logic [STAT_WIDTH-1:0] v);
    logic [STAT_WIDTH-1:0] sum;
    sum = acc + v;
    return sum[STAT_WIDTH-1] ? TOP_VALUE : sum;
  endfunction

endpackage

FILE: hw/rtl/stereo_audio_level_meter_unit.sv
// Top level of the stereo audio level meter: input register, front end, statistics update.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------------
//  request | in        | in_valid / in_stall        | req_type, samples, masks, block_end, index
//  result  | out       | out_valid / out_stall      | stat_value, stat_number
//  config  | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One request per cycle while no held result stalls a read; the rate is set by the single statistics update stage.
// A read result passes in order through the input register, the front-end register
// and the result register.
// rst is synchronous and clears all statistics, previous samples and the register valid bits.
// A held result stalls the next read at the update stage and every request behind
// that read; frames and clears ahead of it keep flowing.
`timescale 1ns / 1ps

module stereo_audio_level_meter_unit #(
  parameter int SAMPLE_WIDTH  = slm_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = slm_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [1:0]                     req_type,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_left,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_right,
  input  logic signed [SAMPLE_WIDTH-1:0]        out_left,
  input  logic signed [SAMPLE_WIDTH-1:0]        out_right,
  input  logic        [slm_pkg::CHANNELS-1:0]   nan_mask,
  input  logic        [slm_pkg::CHANNELS-1:0]   inf_mask,
  input  logic                                  block_end,
  input  logic        [slm_pkg::STAT_INDEX_WIDTH-1:0] stat_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [slm_pkg::STAT_WIDTH-1:0] stat_value,
  output logic        [slm_pkg::STAT_INDEX_WIDTH-1:0] stat_number,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic        [slm_pkg::REG_WIDTH-1:0]  cfg_data
);

  localparam int CH         = slm_pkg::CHANNELS;
  localparam int SW         = SAMPLE_WIDTH;
  localparam int SQ_WIDTH   = 2 * SAMPLE_WIDTH;
  localparam int CLIP_WIDTH = (FRACTION_BITS + 1 > slm_pkg::REG_WIDTH) ?
                              FRACTION_BITS + 1 : slm_pkg::REG_WIDTH;
  localparam int DIFF_WIDTH = (SAMPLE_WIDTH > FRACTION_BITS) ?
                              SAMPLE_WIDTH + 1 : FRACTION_BITS + 1;
  localparam int CHG_WIDTH  = (DIFF_WIDTH > slm_pkg::REG_WIDTH) ?
                              DIFF_WIDTH : slm_pkg::REG_WIDTH;
  localparam int IW         = slm_pkg::STAT_INDEX_WIDTH;
  localparam int VW         = slm_pkg::STAT_WIDTH;

  localparam logic signed [SW-1:0] MIN_RESET = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] MAX_RESET = {1'b1, {(SW-1){1'b0}}};

  // Configuration registers
  logic [CLIP_WIDTH-1:0]         clip_level;
  logic [slm_pkg::REG_WIDTH-1:0] change_level;

  // Input register
  logic                    v1;
  logic [1:0]              req1;
  logic signed [SW-1:0]    smp1 [CH];
  logic [CH-1:0]           nan1;
  logic [CH-1:0]           inf1;
  logic                    blk1;
  logic [IW-1:0]           idx1;

  // Previous samples, tracked in request order at the input register
  logic signed [SW-1:0]    prev_smp [CH];
  logic [1:0]              prev_cls [CH];

  // Front-end results
  slm_pkg::chan_flags_t    flags_c [CH];
  logic [SW-1:0]           mag_c   [CH];
  logic [SQ_WIDTH-1:0]     sq_c    [CH];
  logic [SW-1:0]           tp_c    [CH];
  logic [DIFF_WIDTH-1:0]   diff_c  [2];
  logic [DIFF_WIDTH-1:0]   dmax_c;
  logic [DIFF_WIDTH:0]     dsum_c;
  logic [1:0]              chg_c;
  logic [2:0]              nan_cnt_c;
  logic [2:0]              inf_cnt_c;
  logic [1:0]              clin_c;
  logic [1:0]              clout_c;

  // Front-end register
  logic                    v2;
  logic [1:0]              req2;
  logic [IW-1:0]           idx2;
  logic                    blk2;
  slm_pkg::chan_flags_t    fl2   [CH];
  logic [SW-1:0]           mag2  [CH];
  logic [SQ_WIDTH-1:0]     sq2   [CH];
  logic [SW-1:0]           tp2   [CH];
  logic signed [SW-1:0]    smp2  [CH];
  logic [DIFF_WIDTH-1:0]   dmax2;
  logic [DIFF_WIDTH:0]     dsum2;
  logic [1:0]              chg2;
  logic [2:0]              nan2;
  logic [2:0]              inf2;
  logic [1:0]              clin2;
  logic [1:0]              clout2;

  // Statistics
  logic [VW-1:0]           sq_sum  [CH];
  logic [SW-1:0]           peak    [CH];
  logic [SW-1:0]           tpk     [CH];
  logic signed [SW-1:0]    minv    [CH];
  logic signed [SW-1:0]    maxv    [CH];
  logic [DIFF_WIDTH-1:0]   ldiff;
  logic [VW-1:0]           dsum;
  logic [VW-1:0]           ev      [slm_pkg::COUNTERS];

  // Flow control
  logic                    fire2;
  logic                    move1;
  logic [VW-1:0]           rd_val;
  logic [1:0]              rd_ch;
  logic [2:0]              rd_cnt;

  assign fire2    = v2 && ((req2 != slm_pkg::REQ_READ) || !out_valid || !out_stall);
  assign move1    = v1 && (!v2 || fire2);
  assign in_stall = v1 && !move1;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_level   <= CLIP_WIDTH'(1) << FRACTION_BITS;
      change_level <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        slm_pkg::CFG_CLIP_LEVEL:   clip_level   <= CLIP_WIDTH'(cfg_data);
        slm_pkg::CFG_CHANGE_LEVEL: change_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture a request transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!in_stall) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req1    <= req_type;
      smp1[0] <= in_left;
      smp1[1] <= in_right;
      smp1[2] <= out_left;
      smp1[3] <= out_right;
      nan1    <= nan_mask;
      inf1    <= inf_mask;
      blk1    <= block_end;
      idx1    <= stat_index;
    end
  end

  // Advance previous samples as frames leave the input register; a clear resets them
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CH; i++) begin
        prev_smp[i] <= '0;
        prev_cls[i] <= slm_pkg::CLS_FINITE;
      end
    end else if (move1) begin
      if (req1 == slm_pkg::REQ_FRAME) begin
        for (int i = 0; i < CH; i++) begin
          prev_smp[i] <= smp1[i];
          prev_cls[i] <= flags_c[i].cls;
        end
      end else if (req1 == slm_pkg::REQ_CLEAR) begin
        for (int i = 0; i < CH; i++) begin
          prev_smp[i] <= '0;
          prev_cls[i] <= slm_pkg::CLS_FINITE;
        end
      end
    end
  end

  // Channel front ends
  for (genvar g = 0; g < CH; g++) begin : g_chan
    slm_chan_pre #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .CLIP_WIDTH   (CLIP_WIDTH)
    ) u_pre (
      .sample      (smp1[g]),
      .is_nan      (nan1[g]),
      .is_inf      (inf1[g]),
      .clip_level  (clip_level),
      .prev_sample (prev_smp[g]),
      .prev_cls    (prev_cls[g]),
      .flags       (flags_c[g]),
      .mag         (mag_c[g]),
      .square      (sq_c[g]),
      .tpeak       (tp_c[g])
    );
  end

  // Input/output differences per side
  always_comb begin : diff_calc
    logic [SW:0] dsub;
    logic [SW:0] dmag;
    for (int k = 0; k < 2; k++) begin
      dsub = {smp1[k+2][SW-1], smp1[k+2]} - {smp1[k][SW-1], smp1[k]};
      dmag = dsub[SW] ? (~dsub + 1'b1) : dsub;
      if ((flags_c[k].cls == slm_pkg::CLS_FINITE) &&
          (flags_c[k+2].cls == slm_pkg::CLS_FINITE)) begin
        diff_c[k] = DIFF_WIDTH'(dmag);
      end else if ((flags_c[k].cls == flags_c[k+2].cls) && flags_c[k].cls[1]) begin
        diff_c[k] = '0;
      end else begin
        diff_c[k] = DIFF_WIDTH'(1) << FRACTION_BITS;
      end
    end
  end

  assign dmax_c = (diff_c[1] > diff_c[0]) ? diff_c[1] : diff_c[0];
  assign dsum_c = {1'b0, diff_c[0]} + {1'b0, diff_c[1]};
  assign chg_c  = {1'b0, CHG_WIDTH'(diff_c[0]) > CHG_WIDTH'(change_level)} +
                  {1'b0, CHG_WIDTH'(diff_c[1]) > CHG_WIDTH'(change_level)};

  // Event counts of this frame
  always_comb begin
    nan_cnt_c = '0;
    inf_cnt_c = '0;
    for (int i = 0; i < CH; i++) begin
      nan_cnt_c = nan_cnt_c + {2'b0, nan1[i]};
      inf_cnt_c = inf_cnt_c + {2'b0, inf1[i] & ~nan1[i]};
    end
    clin_c  = {1'b0, flags_c[0].clipped} + {1'b0, flags_c[1].clipped};
    clout_c = {1'b0, flags_c[2].clipped} + {1'b0, flags_c[3].clipped};
  end

  // Front-end register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (!v2 || fire2) begin
      v2 <= move1;
    end
  end

  always_ff @(posedge clk) begin
    if (move1) begin
      req2   <= req1;
      idx2   <= idx1;
      blk2   <= blk1;
      for (int i = 0; i < CH; i++) begin
        fl2[i]  <= flags_c[i];
        mag2[i] <= mag_c[i];
        sq2[i]  <= sq_c[i];
        tp2[i]  <= tp_c[i];
        smp2[i] <= smp1[i];
      end
      dmax2  <= dmax_c;
      dsum2  <= dsum_c;
      chg2   <= chg_c;
      nan2   <= nan_cnt_c;
      inf2   <= inf_cnt_c;
      clin2  <= clin_c;
      clout2 <= clout_c;
    end
  end

  // Update statistics; clear restores reset values
  always_ff @(posedge clk) begin
    if (rst || (fire2 && (req2 == slm_pkg::REQ_CLEAR))) begin
      for (int i = 0; i < CH; i++) begin
        sq_sum[i] <= '0;
        peak[i]   <= '0;
        tpk[i]    <= '0;
        minv[i]   <= MIN_RESET;
        maxv[i]   <= MAX_RESET;
      end
      ldiff <= '0;
      dsum  <= '0;
      for (int j = 0; j < slm_pkg::COUNTERS; j++) begin
        ev[j] <= '0;
      end
    end else if (fire2 && (req2 == slm_pkg::REQ_FRAME)) begin
      for (int i = 0; i < CH; i++) begin
        if (fl2[i].cls == slm_pkg::CLS_FINITE) begin
          sq_sum[i] <= slm_pkg::sat_add(sq_sum[i], VW'(sq2[i]));
          if (mag2[i] > peak[i]) peak[i] <= mag2[i];
          if (tp2[i] > tpk[i]) tpk[i] <= tp2[i];
          if (smp2[i] < minv[i]) minv[i] <= smp2[i];
          if (smp2[i] > maxv[i]) maxv[i] <= smp2[i];
        end
      end
      if (dmax2 > ldiff) ldiff <= dmax2;
      dsum <= slm_pkg::sat_add(dsum, VW'(dsum2));
      ev[slm_pkg::CNT_CHANGED]  <= slm_pkg::sat_add(ev[slm_pkg::CNT_CHANGED], VW'(chg2));
      ev[slm_pkg::CNT_NAN]      <= slm_pkg::sat_add(ev[slm_pkg::CNT_NAN], VW'(nan2));
      ev[slm_pkg::CNT_INF]      <= slm_pkg::sat_add(ev[slm_pkg::CNT_INF], VW'(inf2));
      ev[slm_pkg::CNT_CLIP_IN]  <= slm_pkg::sat_add(ev[slm_pkg::CNT_CLIP_IN], VW'(clin2));
      ev[slm_pkg::CNT_CLIP_OUT] <= slm_pkg::sat_add(ev[slm_pkg::CNT_CLIP_OUT], VW'(clout2));
      ev[slm_pkg::CNT_FRAMES]   <= slm_pkg::sat_add(ev[slm_pkg::CNT_FRAMES], VW'(1'b1));
      ev[slm_pkg::CNT_BLOCKS]   <= slm_pkg::sat_add(ev[slm_pkg::CNT_BLOCKS], VW'(blk2));
    end
  end

  // Select the requested statistic
  assign rd_ch  = idx2[1:0];
  assign rd_cnt = 3'(idx2 - slm_pkg::STAT_CNT_BASE);

  always_comb begin
    rd_val = '0;
    priority if (idx2 < slm_pkg::STAT_PEAK_BASE) rd_val = sq_sum[rd_ch];
    else if (idx2 < slm_pkg::STAT_TP_BASE) rd_val = VW'(peak[rd_ch]);
    else if (idx2 < slm_pkg::STAT_MIN_BASE) rd_val = VW'(tpk[rd_ch]);
    else if (idx2 < slm_pkg::STAT_MAX_BASE) rd_val = VW'(minv[rd_ch]);
    else if (idx2 < slm_pkg::STAT_LDIFF) rd_val = VW'(maxv[rd_ch]);
    else if (idx2 == slm_pkg::STAT_LDIFF) rd_val = VW'(ldiff);
    else if (idx2 == slm_pkg::STAT_DSUM) rd_val = dsum;
    else if (idx2 <= slm_pkg::STAT_LAST) rd_val = ev[rd_cnt];
    else rd_val = '0;
  end

  // Result register; hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire2 && (req2 == slm_pkg::REQ_READ)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire2 && (req2 == slm_pkg::REQ_READ)) begin
      stat_value  <= rd_val;
      stat_number <= idx2;
    end
  end

endmodule

FILE: hw/rtl/slm_chan_pre.sv
// Per-channel front end: class, magnitude, square, clip flag and true peak candidate.
`timescale 1ns / 1ps

module slm_chan_pre #(
  parameter int SAMPLE_WIDTH = slm_pkg::SAMPLE_WIDTH_DEF,
  parameter int CLIP_WIDTH   = slm_pkg::REG_WIDTH
) (
  input  logic signed [SAMPLE_WIDTH-1:0]   sample,
  input  logic                             is_nan,
  input  logic                             is_inf,
  input  logic        [CLIP_WIDTH-1:0]     clip_level,
  input  logic signed [SAMPLE_WIDTH-1:0]   prev_sample,
  input  logic        [1:0]                prev_cls,
  output slm_pkg::chan_flags_t             flags,
  output logic        [SAMPLE_WIDTH-1:0]   mag,
  output logic        [2*SAMPLE_WIDTH-1:0] square,
  output logic        [SAMPLE_WIDTH-1:0]   tpeak
);

  localparam int CMP_WIDTH = (CLIP_WIDTH > SAMPLE_WIDTH) ? CLIP_WIDTH : SAMPLE_WIDTH;
  localparam int EXT_WIDTH = SAMPLE_WIDTH + 2;

  logic        [SAMPLE_WIDTH-1:0] raw;
  logic        [1:0]              cls;
  logic signed [EXT_WIDTH-1:0]    c_ext;
  logic signed [EXT_WIDTH-1:0]    p_ext;
  logic signed [EXT_WIDTH-1:0]    sum_half;
  logic signed [EXT_WIDTH-1:0]    sum_pp;
  logic signed [EXT_WIDTH-1:0]    sum_cc;
  logic        [EXT_WIDTH-1:0]    m_half;
  logic        [EXT_WIDTH-1:0]    m_pp;
  logic        [EXT_WIDTH-1:0]    m_cc;
  logic        [SAMPLE_WIDTH-1:0] t_half;
  logic        [SAMPLE_WIDTH-1:0] t_pp;
  logic        [SAMPLE_WIDTH-1:0] t_cc;
  logic        [SAMPLE_WIDTH-1:0] best;

  function automatic logic [EXT_WIDTH-1:0] abs_ext(input logic signed [EXT_WIDTH-1:0] x);
    logic [EXT_WIDTH-1:0] u;
    u = x;
    return u[EXT_WIDTH-1] ? (~u + 1'b1) : u;
  endfunction

  // Classify: NaN wins over infinity, sign of infinity from the field
  always_comb begin
    priority if (is_nan) cls = slm_pkg::CLS_NAN;
    else if (is_inf) cls = sample[SAMPLE_WIDTH-1] ? slm_pkg::CLS_NINF : slm_pkg::CLS_PINF;
    else cls = slm_pkg::CLS_FINITE;
  end

  // Magnitude and exact square
  assign raw    = sample;
  assign mag    = raw[SAMPLE_WIDTH-1] ? (~raw + 1'b1) : raw;
  assign square = mag * mag;

  assign flags.cls     = cls;
  assign flags.clipped = (cls == slm_pkg::CLS_FINITE) &&
                         (CMP_WIDTH'(mag) >= CMP_WIDTH'(clip_level));

  // Interpolated points between previous and current sample
  assign c_ext    = EXT_WIDTH'(sample);
  assign p_ext    = EXT_WIDTH'(prev_sample);
  assign sum_half = p_ext + c_ext;
  assign sum_pp   = (p_ext <<< 1) + p_ext + c_ext;
  assign sum_cc   = p_ext + (c_ext <<< 1) + c_ext;
  assign m_half   = abs_ext(sum_half);
  assign m_pp     = abs_ext(sum_pp);
  assign m_cc     = abs_ext(sum_cc);
  assign t_half   = m_half[SAMPLE_WIDTH:1];
  assign t_pp     = m_pp[SAMPLE_WIDTH+1:2];
  assign t_cc     = m_cc[SAMPLE_WIDTH+1:2];

  // Skip the interpolated terms after a non-finite sample
  always_comb begin
    best = mag;
    if (prev_cls == slm_pkg::CLS_FINITE) begin
      if (t_half > best) best = t_half;
      if (t_pp > best) best = t_pp;
      if (t_cc > best) best = t_cc;
    end
  end

  assign tpeak = best;

endmodule

FILE: hw/rtl/slm_checker.sv
// Port-level checker of the stereo level meter and its bind to the top level.
`timescale 1ns / 1ps
`include "stereo_audio_level_meter_unit_assert.svh"

module slm_checker #(
  parameter int SAMPLE_WIDTH = slm_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                                        clk,
  input logic                                        rst,
  input logic                                        out_valid,
  input logic                                        out_stall,
  input logic signed [slm_pkg::STAT_WIDTH-1:0]       stat_value,
  input logic        [slm_pkg::STAT_INDEX_WIDTH-1:0] stat_number
);

  // Hold a stalled result
  `SLM_ASSERT_NEXT(a_result_hold, out_valid && out_stall, out_valid && $stable(stat_value) && $stable(stat_number))

  // Unknown statistic numbers read as zero
  `SLM_ASSERT_SAME(a_unknown_zero, out_valid && (stat_number > slm_pkg::STAT_LAST), stat_value == '0)

  // Peaks and true peaks are magnitudes within the sample range
  `SLM_ASSERT_SAME(a_peak_range, out_valid && (stat_number >= slm_pkg::STAT_PEAK_BASE) && (stat_number < slm_pkg::STAT_MIN_BASE), stat_value[slm_pkg::STAT_WIDTH-1:SAMPLE_WIDTH] == '0)

  // Sums and counters never pass the saturation top
  `SLM_ASSERT_SAME(a_sum_top, out_valid && ((stat_number < slm_pkg::STAT_PEAK_BASE) || ((stat_number >= slm_pkg::STAT_DSUM) && (stat_number <= slm_pkg::STAT_LAST))), !stat_value[slm_pkg::STAT_WIDTH-1])

endmodule

bind stereo_audio_level_meter_unit slm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_slm_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .stat_value  (stat_value),
  .stat_number (stat_number)
);
